/* src/wftc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wftc_pkg
// Shared types, field widths and codes for the wildcard five-tuple packet
// classifier: operation codes, verdict and status codes, beat payloads.
// ----------------------------------------------------------------------------
package wftc_pkg;

    // Default table shape
    localparam int RULE_COUNT_DEF = 16;
    localparam int HOOK_COUNT_DEF = 5;
    localparam int IFACE_BITS_DEF = 8;

    // Fixed field widths of the beats
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int HOOK_W   = 3;
    localparam int IFNUM_W  = 8;
    localparam int PROTO_W  = 8;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CLASSIFY = 2'd0,
        OP_ADD      = 2'd1,
        OP_REMOVE   = 2'd2
    } op_t;

    // Verdict codes
    localparam logic VERDICT_ACCEPT = 1'b0;
    localparam logic VERDICT_DIVERT = 1'b1;

    // Status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_HOOK = 1'b1;

    // One request beat
    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  rule_slot;
        logic [HOOK_W-1:0]  hook_point;
        logic [IFNUM_W-1:0] in_interface;
        logic [IFNUM_W-1:0] out_interface;
        logic [PROTO_W-1:0] protocol_number;
        logic [ADDR_W-1:0]  source_address;
        logic [ADDR_W-1:0]  dest_address;
        logic [PORT_W-1:0]  source_port;
        logic [PORT_W-1:0]  dest_port;
        logic               has_ip_header;
        logic               has_transport_header;
    } req_item_t;

    // One result beat
    typedef struct packed {
        logic              verdict;
        logic [SLOT_W-1:0] matched_slot;
        logic              op_status;
    } rsp_item_t;

endpackage

/* src/wftc_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wftc_req_if
// Request channel: valid/ready handshake carrying one classify, add or
// remove beat.
// ----------------------------------------------------------------------------
interface wftc_req_if;
    import wftc_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [SLOT_W-1:0]  rule_slot;
    logic [HOOK_W-1:0]  hook_point;
    logic [IFNUM_W-1:0] in_interface;
    logic [IFNUM_W-1:0] out_interface;
    logic [PROTO_W-1:0] protocol_number;
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  dest_address;
    logic [PORT_W-1:0]  source_port;
    logic [PORT_W-1:0]  dest_port;
    logic               has_ip_header;
    logic               has_transport_header;

    modport source (
        output valid, operation, rule_slot, hook_point, in_interface,
               out_interface, protocol_number, source_address, dest_address,
               source_port, dest_port, has_ip_header, has_transport_header,
        input  ready
    );

    modport sink (
        input  valid, operation, rule_slot, hook_point, in_interface,
               out_interface, protocol_number, source_address, dest_address,
               source_port, dest_port, has_ip_header, has_transport_header,
        output ready
    );
endinterface

/* src/wftc_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wftc_rsp_if
// Result channel: valid/ready handshake carrying the verdict, matched slot
// and operation status of one beat.
// ----------------------------------------------------------------------------
interface wftc_rsp_if;
    import wftc_pkg::*;

    logic              valid;
    logic              ready;
    logic              verdict;
    logic [SLOT_W-1:0] matched_slot;
    logic              op_status;

    modport source (
        output valid, verdict, matched_slot, op_status,
        input  ready
    );

    modport sink (
        input  valid, verdict, matched_slot, op_status,
        output ready
    );
endinterface

/* src/wildcard_five_tuple_packet_classifier_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_five_tuple_packet_classifier_top
// Rule table of wildcard five-tuple capture rules with most-recent-wins
// classification of packet headers.
// ----------------------------------------------------------------------------
// Usage
//   req: one beat per operation. Classify compares the header against all
//        rules at once; add writes a rule into a slot and makes it the most
//        recent one; remove clears a slot.
//   rsp: exactly one beat per request, in request order: verdict and
//        matched_slot for classify, op_status for add (bad hook point).
//   Path: request beat into the input register, then compare and table
//   update into the result register.
//   Throughput: one beat per cycle while rsp is not held; the table update of
//   one beat is seen by the very next beat, as the whole compare, priority
//   pick and rank update sit between the input and the result register.
//   Reset: all rules become invalid and recency ranks clear; rule contents
//   are not cleared and need no sweep.
//   Stall: while rsp is held, the result register keeps its beat and the
//   input register takes one more beat, then req.ready drops until rsp
//   moves.
// ----------------------------------------------------------------------------
module wildcard_five_tuple_packet_classifier_top #(
    parameter int RULE_COUNT = wftc_pkg::RULE_COUNT_DEF,
    parameter int HOOK_COUNT = wftc_pkg::HOOK_COUNT_DEF,
    parameter int IFACE_BITS = wftc_pkg::IFACE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    wftc_req_if.sink   req,
    wftc_rsp_if.source rsp
);
    import wftc_pkg::*;

    localparam int IDX_W  = $clog2(RULE_COUNT);
    localparam int RANK_W = $clog2(RULE_COUNT);

    // Pipeline registers
    logic      in_valid_reg;
    req_item_t in_item_reg;
    logic      out_valid_reg;
    rsp_item_t out_item_reg;
    rsp_item_t out_item_next;

    // Rule table: control state
    logic [RULE_COUNT-1:0] rule_valid_reg;
    logic [RULE_COUNT-1:0] rule_valid_next;
    logic [RANK_W-1:0]     rule_rank_reg  [RULE_COUNT];
    logic [RANK_W-1:0]     rule_rank_next [RULE_COUNT];

    // Rule table: contents
    logic [HOOK_W-1:0]     rule_hook_reg   [RULE_COUNT];
    logic [IFACE_BITS-1:0] rule_in_reg     [RULE_COUNT];
    logic [IFACE_BITS-1:0] rule_out_reg    [RULE_COUNT];
    logic [PROTO_W-1:0]    rule_proto_reg  [RULE_COUNT];
    logic [ADDR_W-1:0]     rule_saddr_reg  [RULE_COUNT];
    logic [ADDR_W-1:0]     rule_daddr_reg  [RULE_COUNT];
    logic [PORT_W-1:0]     rule_sport_reg  [RULE_COUNT];
    logic [PORT_W-1:0]     rule_dport_reg  [RULE_COUNT];

    // Processing signals
    logic                  advance;
    logic                  process;
    logic [IDX_W-1:0]      slot_idx;
    logic                  slot_in_range;
    logic                  slot_valid;
    logic [RANK_W-1:0]     slot_rank;
    logic                  hook_ok;
    logic [IFACE_BITS-1:0] pkt_in;
    logic [IFACE_BITS-1:0] pkt_out;
    logic [RANK_W-1:0]     others_count;
    logic [RULE_COUNT-1:0] is_slot;
    logic [RULE_COUNT-1:0] rule_match;
    logic [RULE_COUNT-1:0] rule_win;
    logic                  do_add;
    logic                  do_remove;
    logic                  any_match;
    logic [SLOT_W-1:0]     win_slot;

    // Handshake: result register moves when empty or taken
    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;
    assign process   = in_valid_reg && advance;

    assign rsp.valid        = out_valid_reg;
    assign rsp.verdict      = out_item_reg.verdict;
    assign rsp.matched_slot = out_item_reg.matched_slot;
    assign rsp.op_status    = out_item_reg.op_status;

    // Decode the addressed slot and the packet interface numbers
    assign slot_in_range = (32'(in_item_reg.rule_slot) < RULE_COUNT);
    assign slot_idx      = IDX_W'(in_item_reg.rule_slot);
    assign slot_valid    = slot_in_range && rule_valid_reg[slot_idx];
    assign slot_rank     = rule_rank_reg[slot_idx];
    assign hook_ok       = (32'(in_item_reg.hook_point) < HOOK_COUNT);
    assign pkt_in        = IFACE_BITS'(in_item_reg.in_interface);
    assign pkt_out       = IFACE_BITS'(in_item_reg.out_interface);

    // Compare the header against every rule in parallel
    always_comb
    begin
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            logic if_ok;
            logic ip_ok;
            logic tp_ok;
            if_ok = (rule_in_reg[i] == '0 || rule_in_reg[i] == pkt_in) &&
                    (rule_out_reg[i] == '0 || rule_out_reg[i] == pkt_out);
            ip_ok = !in_item_reg.has_ip_header ||
                    ((rule_proto_reg[i] == '0 ||
                      rule_proto_reg[i] == in_item_reg.protocol_number) &&
                     (rule_saddr_reg[i] == '0 ||
                      rule_saddr_reg[i] == in_item_reg.source_address) &&
                     (rule_daddr_reg[i] == '0 ||
                      rule_daddr_reg[i] == in_item_reg.dest_address));
            tp_ok = !in_item_reg.has_transport_header ||
                    ((rule_sport_reg[i] == '0 ||
                      rule_sport_reg[i] == in_item_reg.source_port) &&
                     (rule_dport_reg[i] == '0 ||
                      rule_dport_reg[i] == in_item_reg.dest_port));
            rule_match[i] = rule_valid_reg[i] &&
                            rule_hook_reg[i] == in_item_reg.hook_point &&
                            if_ok && ip_ok && tp_ok;
        end
    end

    // Pick the matching rule that no more recent matching rule outranks
    always_comb
    begin
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            logic beaten;
            beaten = 1'b0;
            for (int j = 0; j < RULE_COUNT; j++)
            begin
                if (j != i && rule_match[j] && rule_rank_reg[j] > rule_rank_reg[i])
                begin
                    beaten = 1'b1;
                end
            end
            rule_win[i] = rule_match[i] && !beaten;
        end
    end

    // Encode the winner; ranks are unique so at most one bit is set
    always_comb
    begin
        win_slot = '0;
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            if (rule_win[i])
            begin
                win_slot = win_slot | SLOT_W'(i);
            end
        end
    end
    assign any_match = |rule_win;

    // Count valid rules other than the addressed slot
    always_comb
    begin
        others_count = '0;
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            is_slot[i] = slot_in_range && (slot_idx == IDX_W'(i));
            if (rule_valid_reg[i] && !is_slot[i])
            begin
                others_count = others_count + RANK_W'(1);
            end
        end
    end

    // Decode the operation and build the result beat
    always_comb
    begin
        do_add        = 1'b0;
        do_remove     = 1'b0;
        out_item_next = '0;
        unique case (in_item_reg.operation)
            OP_CLASSIFY:
            begin
                out_item_next.verdict      = any_match ? VERDICT_DIVERT : VERDICT_ACCEPT;
                out_item_next.matched_slot = any_match ? win_slot : '0;
                out_item_next.op_status    = STATUS_OK;
            end
            OP_ADD:
            begin
                out_item_next.op_status = hook_ok ? STATUS_OK : STATUS_BAD_HOOK;
                do_add = hook_ok && slot_in_range;
            end
            OP_REMOVE:
            begin
                do_remove = slot_valid;
            end
            default:
            begin
                out_item_next = '0;
            end
        endcase
    end

    // Next valid bits and recency ranks
    always_comb
    begin
        rule_valid_next = rule_valid_reg;
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            rule_rank_next[i] = rule_rank_reg[i];
            if (do_add || do_remove)
            begin
                if (is_slot[i])
                begin
                    rule_valid_next[i] = do_add;
                    rule_rank_next[i]  = do_add ? others_count : '0;
                end
                else if (slot_valid && rule_valid_reg[i] && rule_rank_reg[i] > slot_rank)
                begin
                    // close the gap left by the slot leaving the order
                    rule_rank_next[i] = rule_rank_reg[i] - RANK_W'(1);
                end
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_item_reg.operation            <= req.operation;
            in_item_reg.rule_slot            <= req.rule_slot;
            in_item_reg.hook_point           <= req.hook_point;
            in_item_reg.in_interface         <= req.in_interface;
            in_item_reg.out_interface        <= req.out_interface;
            in_item_reg.protocol_number      <= req.protocol_number;
            in_item_reg.source_address       <= req.source_address;
            in_item_reg.dest_address         <= req.dest_address;
            in_item_reg.source_port          <= req.source_port;
            in_item_reg.dest_port            <= req.dest_port;
            in_item_reg.has_ip_header        <= req.has_ip_header;
            in_item_reg.has_transport_header <= req.has_transport_header;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // Rule control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_valid_reg <= '0;
            for (int i = 0; i < RULE_COUNT; i++)
            begin
                rule_rank_reg[i] <= '0;
            end
        end
        else if (process)
        begin
            rule_valid_reg <= rule_valid_next;
            for (int i = 0; i < RULE_COUNT; i++)
            begin
                rule_rank_reg[i] <= rule_rank_next[i];
            end
        end
    end

    // Rule contents: written by add only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RULE_COUNT; i++)
        begin
            if (process && do_add && is_slot[i])
            begin
                rule_hook_reg[i]  <= in_item_reg.hook_point;
                rule_in_reg[i]    <= pkt_in;
                rule_out_reg[i]   <= pkt_out;
                rule_proto_reg[i] <= in_item_reg.protocol_number;
                rule_saddr_reg[i] <= in_item_reg.source_address;
                rule_daddr_reg[i] <= in_item_reg.dest_address;
                rule_sport_reg[i] <= in_item_reg.source_port;
                rule_dport_reg[i] <= in_item_reg.dest_port;
            end
        end
    end

endmodule

/* src/wftc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wftc_checker
// Port-level checks on the classifier: result consistency, result origin
// and input readiness; bound to the top level.
// ----------------------------------------------------------------------------
module wftc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       verdict,
    input logic [wftc_pkg::SLOT_W-1:0] matched_slot,
    input logic                       op_status
);
    import wftc_pkg::*;

    // A held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(verdict) && $stable(matched_slot) && $stable(op_status))
    else $error("result beat changed while stalled");

    // A divert comes only from a classify, which never reports an error
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && verdict == VERDICT_DIVERT |-> op_status == STATUS_OK)
    else $error("divert verdict with error status");

    // An accept verdict names no slot
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && verdict == VERDICT_ACCEPT |-> matched_slot == '0)
    else $error("accept verdict with non-zero slot");

    // A new result appears only after a request beat has passed the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("result beat without a request beat");

    // With the result register empty, requests are never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
    else $error("request stalled with empty result register");

endmodule

bind wildcard_five_tuple_packet_classifier_top wftc_checker u_wftc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .verdict      (rsp.verdict),
    .matched_slot (rsp.matched_slot),
    .op_status    (rsp.op_status)
);
